[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers used by the checker file cpt_chk.sv
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define CPT_ASSERT_IMPL(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("cpt same-cycle check failed");

// next-cycle implication, disabled while reset is low
`define CPT_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("cpt next-cycle check failed");

`endif

[hdl/cpt_pkg.sv]
// ----------------------------------------------------------------------------
// cpt_pkg
// widths, region codes and beat layout of the closest-point-on-triangle core
// ----------------------------------------------------------------------------
package cpt_pkg;

    localparam int COORD_W = 32;
    localparam int WGT_W   = 16;
    localparam logic [WGT_W:0] WGT_ONE = (WGT_W+1)'(1) << WGT_W;

    localparam int DIF_W  = COORD_W + 1;
    localparam int PRD_W  = 2 * DIF_W;
    localparam int DOT_W  = PRD_W + 2;
    localparam int EXT_W  = DOT_W + 2;
    localparam int HALF_W = DOT_W / 2;
    localparam int BIG_W  = 2 * DOT_W;
    localparam int WIDE_W = BIG_W + 4;
    localparam int DIV_W  = WIDE_W - 1;
    localparam int QUO_W  = WGT_W + 1;
    localparam int PM_W   = COORD_W + WGT_W + 2;
    localparam int SUM_W  = PM_W + 2;
    localparam int DST_W  = 63;

    localparam int S_TDATA_W  = 12 * COORD_W;
    localparam int M_NX_LO    = 0;
    localparam int M_WA_LO    = 3 * COORD_W;
    localparam int M_WB_LO    = M_WA_LO + WGT_W + 1;
    localparam int M_WC_LO    = M_WB_LO + WGT_W + 1;
    localparam int M_DST_LO   = M_WC_LO + WGT_W + 1;
    localparam int M_FIELDS_W = M_DST_LO + DST_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;
    localparam int M_TUSER_W  = 4;

    typedef enum logic [2:0] {
        RGN_A  = 3'd0,
        RGN_B  = 3'd1,
        RGN_AB = 3'd2,
        RGN_C  = 3'd3,
        RGN_AC = 3'd4,
        RGN_BC = 3'd5,
        RGN_IN = 3'd6
    } region_t;

    typedef enum logic [1:0] {
        RAT_ZERO = 2'd0,
        RAT_ONE  = 2'd1,
        RAT_DIV  = 2'd2
    } rat_mode_t;

endpackage

[hdl/closest_point_on_triangle_core.sv]
// ----------------------------------------------------------------------------
// closest_point_on_triangle_core
// pipelined closest point on a triangle with barycentric weights, squared
// distance and voronoi region code
// ----------------------------------------------------------------------------
// channel | dir | beat contents
// s_      | in  | tdata: query x/y/z, corner a x/y/z, b x/y/z, c x/y/z
// m_      | out | tdata: nearest x/y/z, weights a/b/c, distance squared
//         |     | tuser: region, degenerate
//
// one beat per cycle in, one per cycle out while the output is not stalled;
// the weights are formed by the 17-stage restoring divider
// aresetn clears only the stage valid bits
// a stalled output freezes every stage; s_tready is low only then
// ----------------------------------------------------------------------------
module closest_point_on_triangle_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // query_x, query_y, query_z, corner_a_x/y/z, corner_b_x/y/z, corner_c_x/y/z
    input  logic [cpt_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // nearest_x, nearest_y, nearest_z, weight_a, weight_b, weight_c,
    // distance_squared, zero fill
    output logic [cpt_pkg::M_TDATA_W-1:0]  m_tdata,
    // region, degenerate
    output logic [cpt_pkg::M_TUSER_W-1:0]  m_tuser
);

    localparam int CW  = cpt_pkg::COORD_W;
    localparam int WW  = cpt_pkg::WGT_W;
    localparam int DFW = cpt_pkg::DIF_W;
    localparam int PW  = cpt_pkg::PRD_W;
    localparam int DTW = cpt_pkg::DOT_W;
    localparam int EW  = cpt_pkg::EXT_W;
    localparam int HW  = cpt_pkg::HALF_W;
    localparam int BW  = cpt_pkg::BIG_W;
    localparam int XW  = cpt_pkg::WIDE_W;
    localparam int DVW = cpt_pkg::DIV_W;
    localparam int QW  = cpt_pkg::QUO_W;
    localparam int MW  = cpt_pkg::PM_W;
    localparam int SW  = cpt_pkg::SUM_W;
    localparam int DSW = cpt_pkg::DST_W;

    localparam int NSTEP = QW;
    localparam int ST_DV = 7;
    localparam int ST_W  = ST_DV + NSTEP + 1;
    localparam int ST_M  = ST_W + 1;
    localparam int ST_N  = ST_M + 1;
    localparam int ST_Q  = ST_N + 1;
    localparam int ST_O  = ST_Q + 1;

    typedef logic [2:0][CW-1:0] vec_t;
    typedef struct packed { vec_t p, a, b, c; } crd_t;
    typedef struct packed { logic [2:0][DFW-1:0] ab, ac, ap; } s1_t;
    typedef struct packed { logic [2:0][PW-1:0] aa, x, cc, d1, d2; } s2_t;
    typedef struct packed { logic [DTW-1:0] aa, x, cc, d1, d2; } s3_t;
    typedef struct packed {
        logic [2*HW-1:0] ll;
        logic [2*HW:0]   lh, hl;
        logic [2*HW-1:0] hh;
    } pp_t;
    typedef struct packed {
        logic [EW-1:0] d1, d2, d3, d4, d5, d6, e1, e2, aa, cc, bb;
    } dots_t;
    typedef struct packed { pp_t [5:0] pp; dots_t dt; } s4_t;
    typedef struct packed { logic [5:0][BW-1:0] pr; dots_t dt; } s5_t;
    typedef struct packed { logic [XW-1:0] va, vb, vc, den; dots_t dt; } s6_t;
    typedef struct packed {
        cpt_pkg::rat_mode_t mode;
        logic [DVW-1:0]     rem, den;
        logic [QW-1:0]      q;
    } rat_t;
    typedef struct packed {
        cpt_pkg::region_t region;
        logic             degen;
        rat_t             ra, rb;
    } dv_t;
    typedef struct packed {
        cpt_pkg::region_t  region;
        logic              degen;
        logic [2:0][WW:0]  wt;
    } sw_t;
    typedef struct packed { sw_t hd; logic [2:0][2:0][MW-1:0] pr; } sm_t;
    typedef struct packed { sw_t hd; vec_t nr; } sn_t;
    typedef struct packed { sw_t hd; vec_t nr; logic [2:0][PW-1:0] sq; } sq_t;
    typedef struct packed { sw_t hd; vec_t nr; logic [DSW-1:0] dsq; } so_t;

    function automatic logic [DTW-1:0] sum3(logic [2:0][PW-1:0] v);
        return DTW'($signed(v[0])) + DTW'($signed(v[1])) + DTW'($signed(v[2]));
    endfunction

    function automatic logic [EW-1:0] ext(logic [DTW-1:0] v);
        return EW'($signed(v));
    endfunction

    function automatic logic [XW-1:0] wxb(logic [BW-1:0] v);
        return XW'($signed(v));
    endfunction

    function automatic logic [XW-1:0] wxe(logic [EW-1:0] v);
        return XW'($signed(v));
    endfunction

    function automatic logic [BW-1:0] pp_join(pp_t pp);
        logic signed [BW-1:0] e_ll, e_lh, e_hl, e_hh;
        e_ll = BW'(pp.ll);
        e_lh = BW'($signed(pp.lh));
        e_hl = BW'($signed(pp.hl));
        e_hh = BW'($signed(pp.hh));
        return e_ll + (e_lh <<< HW) + (e_hl <<< HW) + (e_hh <<< (2*HW));
    endfunction

    function automatic rat_t rat_init(logic [XW-1:0] num, logic [XW-1:0] den);
        rat_t r;
        r.rem = num[DVW-1:0];
        r.den = den[DVW-1:0];
        r.q   = '0;
        if ($signed(num) <= 0 || $signed(den) <= 0) begin
            r.mode = cpt_pkg::RAT_ZERO;
        end else if ($signed(num) >= $signed(den)) begin
            r.mode = cpt_pkg::RAT_ONE;
        end else begin
            r.mode = cpt_pkg::RAT_DIV;
        end
        return r;
    endfunction

    function automatic rat_t rat_step(rat_t r);
        logic [DVW:0] two;
        logic         ge;
        rat_t         n;
        n     = r;
        two   = {r.rem, 1'b0};
        ge    = two >= {1'b0, r.den};
        n.rem = ge ? DVW'(two - {1'b0, r.den}) : two[DVW-1:0];
        n.q   = {r.q[QW-2:0], ge};
        return n;
    endfunction

    function automatic logic [WW:0] rat_val(rat_t r);
        logic [QW:0] qp;
        logic [WW:0] v;
        qp = {1'b0, r.q} + 1'b1;
        case (r.mode)
            cpt_pkg::RAT_ONE: v = cpt_pkg::WGT_ONE;
            cpt_pkg::RAT_DIV: v = qp[QW:1];
            default:          v = '0;
        endcase
        return v;
    endfunction

    logic            en;
    logic [ST_O:1]   vld_reg;
    crd_t            crd_in;
    crd_t            crd_reg [1:ST_N];
    s1_t             s1_reg, s1_next;
    s2_t             s2_reg, s2_next;
    s3_t             s3_reg, s3_next;
    s4_t             s4_reg, s4_next;
    s5_t             s5_reg, s5_next;
    s6_t             s6_reg, s6_next;
    dv_t             dv0_next;
    dv_t             dv_reg [0:NSTEP];
    dv_t             dv_next [0:NSTEP];
    sw_t             sw_reg, sw_next;
    sm_t             sm_reg, sm_next;
    sn_t             sn_reg, sn_next;
    sq_t             sq_reg, sq_next;
    so_t             so_reg, so_next;

    assign en       = !vld_reg[ST_O] || m_tready;
    assign s_tready = en;
    assign m_tvalid = vld_reg[ST_O];
    assign m_tdata  = {(cpt_pkg::M_TDATA_W - cpt_pkg::M_FIELDS_W)'(0), so_reg.dsq,
                       so_reg.hd.wt[2], so_reg.hd.wt[1], so_reg.hd.wt[0],
                       so_reg.nr[2], so_reg.nr[1], so_reg.nr[0]};
    assign m_tuser  = {so_reg.hd.degen, so_reg.hd.region};

    // edge vectors
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            crd_in.p[k] = s_tdata[k*CW +: CW];
            crd_in.a[k] = s_tdata[(3+k)*CW +: CW];
            crd_in.b[k] = s_tdata[(6+k)*CW +: CW];
            crd_in.c[k] = s_tdata[(9+k)*CW +: CW];
        end
        for (int k = 0; k < 3; k++) begin
            s1_next.ab[k] = {crd_in.b[k][CW-1], crd_in.b[k]}
                          - {crd_in.a[k][CW-1], crd_in.a[k]};
            s1_next.ac[k] = {crd_in.c[k][CW-1], crd_in.c[k]}
                          - {crd_in.a[k][CW-1], crd_in.a[k]};
            s1_next.ap[k] = {crd_in.p[k][CW-1], crd_in.p[k]}
                          - {crd_in.a[k][CW-1], crd_in.a[k]};
        end
    end

    // per-axis products
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            s2_next.aa[k] = $signed(s1_reg.ab[k]) * $signed(s1_reg.ab[k]);
            s2_next.x[k]  = $signed(s1_reg.ab[k]) * $signed(s1_reg.ac[k]);
            s2_next.cc[k] = $signed(s1_reg.ac[k]) * $signed(s1_reg.ac[k]);
            s2_next.d1[k] = $signed(s1_reg.ab[k]) * $signed(s1_reg.ap[k]);
            s2_next.d2[k] = $signed(s1_reg.ac[k]) * $signed(s1_reg.ap[k]);
        end
    end

    // dot products
    always_comb begin
        s3_next.aa = sum3(s2_reg.aa);
        s3_next.x  = sum3(s2_reg.x);
        s3_next.cc = sum3(s2_reg.cc);
        s3_next.d1 = sum3(s2_reg.d1);
        s3_next.d2 = sum3(s2_reg.d2);
    end

    // partial products of the region determinants, derived dots
    always_comb begin
        logic [5:0][DTW-1:0] op_a, op_b;
        logic [HW-1:0]       al, ah, bl, bh;
        op_a[0] = s3_reg.x;  op_b[0] = s3_reg.d1;
        op_a[1] = s3_reg.aa; op_b[1] = s3_reg.d2;
        op_a[2] = s3_reg.x;  op_b[2] = s3_reg.d2;
        op_a[3] = s3_reg.cc; op_b[3] = s3_reg.d1;
        op_a[4] = s3_reg.aa; op_b[4] = s3_reg.cc;
        op_a[5] = s3_reg.x;  op_b[5] = s3_reg.x;
        for (int i = 0; i < 6; i++) begin
            al = op_a[i][HW-1:0];
            ah = op_a[i][DTW-1:HW];
            bl = op_b[i][HW-1:0];
            bh = op_b[i][DTW-1:HW];
            s4_next.pp[i].ll = al * bl;
            s4_next.pp[i].lh = $signed({1'b0, al}) * $signed(bh);
            s4_next.pp[i].hl = $signed(ah) * $signed({1'b0, bl});
            s4_next.pp[i].hh = $signed(ah) * $signed(bh);
        end
        s4_next.dt.d1 = ext(s3_reg.d1);
        s4_next.dt.d2 = ext(s3_reg.d2);
        s4_next.dt.d3 = ext(s3_reg.d1) - ext(s3_reg.aa);
        s4_next.dt.d4 = ext(s3_reg.d2) - ext(s3_reg.x);
        s4_next.dt.d5 = ext(s3_reg.d1) - ext(s3_reg.x);
        s4_next.dt.d6 = ext(s3_reg.d2) - ext(s3_reg.cc);
        s4_next.dt.e1 = ext(s3_reg.d2) - ext(s3_reg.x) - ext(s3_reg.d1) + ext(s3_reg.aa);
        s4_next.dt.e2 = ext(s3_reg.d1) - ext(s3_reg.x) - ext(s3_reg.d2) + ext(s3_reg.cc);
        s4_next.dt.aa = ext(s3_reg.aa);
        s4_next.dt.cc = ext(s3_reg.cc);
        s4_next.dt.bb = ext(s3_reg.aa) + ext(s3_reg.cc) - (ext(s3_reg.x) << 1);
    end

    always_comb begin
        for (int i = 0; i < 6; i++) begin
            s5_next.pr[i] = pp_join(s4_reg.pp[i]);
        end
        s5_next.dt = s4_reg.dt;
    end

    // region determinants
    always_comb begin
        s6_next.vc  = wxb(s5_reg.pr[1]) - wxb(s5_reg.pr[0]);
        s6_next.vb  = wxb(s5_reg.pr[3]) - wxb(s5_reg.pr[2]);
        s6_next.den = wxb(s5_reg.pr[4]) - wxb(s5_reg.pr[5]);
        s6_next.va  = s6_next.den - s6_next.vb - s6_next.vc;
        s6_next.dt  = s5_reg.dt;
    end

    // region tests and divider setup
    always_comb begin
        dv0_next.region = cpt_pkg::RGN_A;
        dv0_next.degen  = 1'b0;
        dv0_next.ra     = rat_init('0, '0);
        dv0_next.rb     = rat_init('0, '0);
        if ($signed(s6_reg.dt.d1) <= 0 && $signed(s6_reg.dt.d2) <= 0) begin
            dv0_next.region = cpt_pkg::RGN_A;
        end else if ($signed(s6_reg.dt.d3) >= 0
                     && $signed(s6_reg.dt.d4) <= $signed(s6_reg.dt.d3)) begin
            dv0_next.region = cpt_pkg::RGN_B;
        end else if ($signed(s6_reg.vc) <= 0 && $signed(s6_reg.dt.d1) >= 0
                     && $signed(s6_reg.dt.d3) <= 0) begin
            dv0_next.region = cpt_pkg::RGN_AB;
            dv0_next.ra     = rat_init(wxe(s6_reg.dt.d1), wxe(s6_reg.dt.aa));
        end else if ($signed(s6_reg.dt.d6) >= 0
                     && $signed(s6_reg.dt.d5) <= $signed(s6_reg.dt.d6)) begin
            dv0_next.region = cpt_pkg::RGN_C;
        end else if ($signed(s6_reg.vb) <= 0 && $signed(s6_reg.dt.d2) >= 0
                     && $signed(s6_reg.dt.d6) <= 0) begin
            dv0_next.region = cpt_pkg::RGN_AC;
            dv0_next.ra     = rat_init(wxe(s6_reg.dt.d2), wxe(s6_reg.dt.cc));
        end else if ($signed(s6_reg.va) <= 0 && $signed(s6_reg.dt.e1) >= 0
                     && $signed(s6_reg.dt.e2) >= 0) begin
            dv0_next.region = cpt_pkg::RGN_BC;
            dv0_next.ra     = rat_init(wxe(s6_reg.dt.e1), wxe(s6_reg.dt.bb));
        end else if ($signed(s6_reg.den) <= 0) begin
            dv0_next.degen  = 1'b1;
        end else begin
            dv0_next.region = cpt_pkg::RGN_IN;
            dv0_next.ra     = rat_init(s6_reg.vb, s6_reg.den);
            dv0_next.rb     = rat_init(s6_reg.vc, s6_reg.den);
        end
    end

    // one quotient bit per stage
    always_comb begin
        dv_next[0] = dv0_next;
        for (int i = 1; i <= NSTEP; i++) begin
            dv_next[i].region = dv_reg[i-1].region;
            dv_next[i].degen  = dv_reg[i-1].degen;
            dv_next[i].ra     = rat_step(dv_reg[i-1].ra);
            dv_next[i].rb     = rat_step(dv_reg[i-1].rb);
        end
    end

    // weights
    always_comb begin
        logic [WW:0] ta, tb;
        ta = rat_val(dv_reg[NSTEP].ra);
        tb = rat_val(dv_reg[NSTEP].rb);
        sw_next.region = dv_reg[NSTEP].region;
        sw_next.degen  = dv_reg[NSTEP].degen;
        sw_next.wt     = '0;
        case (dv_reg[NSTEP].region)
            cpt_pkg::RGN_A: sw_next.wt[0] = cpt_pkg::WGT_ONE;
            cpt_pkg::RGN_B: sw_next.wt[1] = cpt_pkg::WGT_ONE;
            cpt_pkg::RGN_AB: begin
                sw_next.wt[0] = cpt_pkg::WGT_ONE - ta;
                sw_next.wt[1] = ta;
            end
            cpt_pkg::RGN_C: sw_next.wt[2] = cpt_pkg::WGT_ONE;
            cpt_pkg::RGN_AC: begin
                sw_next.wt[0] = cpt_pkg::WGT_ONE - ta;
                sw_next.wt[2] = ta;
            end
            cpt_pkg::RGN_BC: begin
                sw_next.wt[1] = cpt_pkg::WGT_ONE - ta;
                sw_next.wt[2] = ta;
            end
            cpt_pkg::RGN_IN: begin
                if ({1'b0, ta} + {1'b0, tb} > {1'b0, cpt_pkg::WGT_ONE}) begin
                    tb = cpt_pkg::WGT_ONE - ta;
                end
                sw_next.wt[0] = cpt_pkg::WGT_ONE - ta - tb;
                sw_next.wt[1] = ta;
                sw_next.wt[2] = tb;
            end
            default: sw_next.wt[0] = cpt_pkg::WGT_ONE;
        endcase
    end

    // weighted corners
    always_comb begin
        sm_next.hd = sw_reg;
        for (int k = 0; k < 3; k++) begin
            sm_next.pr[k][0] = $signed({1'b0, sw_reg.wt[0]}) * $signed(crd_reg[ST_W].a[k]);
            sm_next.pr[k][1] = $signed({1'b0, sw_reg.wt[1]}) * $signed(crd_reg[ST_W].b[k]);
            sm_next.pr[k][2] = $signed({1'b0, sw_reg.wt[2]}) * $signed(crd_reg[ST_W].c[k]);
        end
    end

    // nearest point, round half up
    always_comb begin
        logic [SW-1:0] acc;
        sn_next.hd = sm_reg.hd;
        for (int k = 0; k < 3; k++) begin
            acc = SW'($signed(sm_reg.pr[k][0])) + SW'($signed(sm_reg.pr[k][1]))
                + SW'($signed(sm_reg.pr[k][2])) + (SW'(1) << (WW - 1));
            sn_next.nr[k] = acc[WW +: CW];
        end
    end

    always_comb begin
        logic [DFW-1:0] dd;
        sq_next.hd = sn_reg.hd;
        sq_next.nr = sn_reg.nr;
        for (int k = 0; k < 3; k++) begin
            dd = {crd_reg[ST_N].p[k][CW-1], crd_reg[ST_N].p[k]}
               - {sn_reg.nr[k][CW-1], sn_reg.nr[k]};
            sq_next.sq[k] = $signed(dd) * $signed(dd);
        end
    end

    // distance sum with saturation
    always_comb begin
        logic [PW+1:0] tot;
        tot = (PW+2)'(sq_reg.sq[0]) + (PW+2)'(sq_reg.sq[1]) + (PW+2)'(sq_reg.sq[2]);
        so_next.hd = sq_reg.hd;
        so_next.nr = sq_reg.nr;
        if (tot[PW+1:DSW] != '0) begin
            so_next.dsq = '1;
        end else begin
            so_next.dsq = tot[DSW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[ST_O-1:1], s_tvalid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            crd_reg[1] <= crd_in;
            for (int i = 2; i <= ST_N; i++) begin
                crd_reg[i] <= crd_reg[i-1];
            end
            s1_reg <= s1_next;
            s2_reg <= s2_next;
            s3_reg <= s3_next;
            s4_reg <= s4_next;
            s5_reg <= s5_next;
            s6_reg <= s6_next;
            for (int i = 0; i <= NSTEP; i++) begin
                dv_reg[i] <= dv_next[i];
            end
            sw_reg <= sw_next;
            sm_reg <= sm_next;
            sn_reg <= sn_next;
            sq_reg <= sq_next;
            so_reg <= so_next;
        end
    end

endmodule

[hdl/cpt_chk.sv]
// ----------------------------------------------------------------------------
// cpt_chk
// port-level checks of the closest-point-on-triangle core
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cpt_chk (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [cpt_pkg::M_TDATA_W-1:0]  m_tdata,
    input logic [cpt_pkg::M_TUSER_W-1:0]  m_tuser
);

    logic [cpt_pkg::WGT_W:0]   wa, wb, wc;
    logic [cpt_pkg::WGT_W+1:0] wsum;
    logic [2:0]                rgn;

    assign wa   = m_tdata[cpt_pkg::M_WA_LO +: cpt_pkg::WGT_W+1];
    assign wb   = m_tdata[cpt_pkg::M_WB_LO +: cpt_pkg::WGT_W+1];
    assign wc   = m_tdata[cpt_pkg::M_WC_LO +: cpt_pkg::WGT_W+1];
    assign wsum = {1'b0, wa} + {1'b0, wb} + {1'b0, wc};
    assign rgn  = m_tuser[2:0];

    `CPT_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    `CPT_ASSERT_IMPL(a_ready_free, aclk, aresetn, !m_tvalid, s_tready)
    `CPT_ASSERT_IMPL(a_weight_sum, aclk, aresetn, m_tvalid, wsum == {1'b0, cpt_pkg::WGT_ONE})
    `CPT_ASSERT_IMPL(a_degen_vtx, aclk, aresetn, m_tvalid && m_tuser[3], (rgn == cpt_pkg::RGN_A) && (wa == cpt_pkg::WGT_ONE))
    `CPT_ASSERT_IMPL(a_far_vtx, aclk, aresetn, m_tvalid && (rgn == cpt_pkg::RGN_B || rgn == cpt_pkg::RGN_C), wa == '0)

endmodule

bind closest_point_on_triangle_core cpt_chk u_cpt_chk (.*);

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the closest-point-on-triangle core: a directed
// table of corner cases followed by random triangles and query points; each
// result beat is compared with an exact wide-integer model of the region
// tests, or with hand-written values for the typed rows of the table
module tb_top;

    localparam int ONE   = 65536;
    localparam int LIMIT = 400000;
    localparam int N_RND = 1930;

    typedef logic signed [255:0] wide_t;
    typedef logic signed [31:0] coord_t;

    typedef struct {
        coord_t            nx, ny, nz;
        logic [16:0]       wa, wb, wc;
        logic [62:0]       dsq;
        cpt_pkg::region_t  rgn;
        logic              degen;
    } nearest_t;

    typedef struct {
        coord_t   c [12];
        bit       typed;
        nearest_t want;
    } query_t;

    logic                            aclk = 0;
    logic                            aresetn = 0;
    logic                            s_tvalid = 0;
    logic                            s_tready;
    logic [cpt_pkg::S_TDATA_W-1:0]   s_tdata = '0;
    logic                            m_tvalid;
    logic                            m_tready = 0;
    logic [cpt_pkg::M_TDATA_W-1:0]   m_tdata;
    logic [cpt_pkg::M_TUSER_W-1:0]   m_tuser;

    nearest_t nearest_q [$];
    query_t   table_rows [$];
    query_t   cur;
    int       idle_pct = 0;
    int       stall_pct = 0;
    int       hold_left = 0;
    int       cycles = 0;
    bit       failed = 0;

    closest_point_on_triangle_core u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always #4 aclk = ~aclk;

    function automatic wide_t dot3(wide_t a [3], wide_t b [3]);
        return a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
    endfunction

    function automatic logic [16:0] weight_of(wide_t num, wide_t den);
        wide_t q;
        if (num <= 0 || den <= 0) return 17'd0;
        q = ((num <<< 17) + den) / (den <<< 1);
        if (q > ONE) return 17'(ONE);
        return q[16:0];
    endfunction

    function automatic nearest_t closest_point(coord_t c [12]);
        nearest_t r;
        wide_t p [3], a [3], b [3], cc [3], ab [3], ac [3], ap [3], bp [3], cp [3];
        wide_t d1, d2, d3, d4, d5, d6, va, vb, vc, e1, e2, den, s, dd, dist_sq;
        logic [16:0] wt [3], t, v, w;
        coord_t nr [3];
        for (int k = 0; k < 3; k++) begin
            p[k] = c[k]; a[k] = c[3 + k]; b[k] = c[6 + k]; cc[k] = c[9 + k];
            ab[k] = b[k] - a[k]; ac[k] = cc[k] - a[k]; ap[k] = p[k] - a[k];
            bp[k] = p[k] - b[k]; cp[k] = p[k] - cc[k];
        end
        r.degen = 0;
        wt[0] = 17'(ONE); wt[1] = 0; wt[2] = 0;
        d1 = dot3(ab, ap); d2 = dot3(ac, ap);
        d3 = dot3(ab, bp); d4 = dot3(ac, bp);
        d5 = dot3(ab, cp); d6 = dot3(ac, cp);
        vc = d1 * d4 - d3 * d2;
        vb = d5 * d2 - d1 * d6;
        va = d3 * d6 - d5 * d4;
        e1 = d4 - d3; e2 = d5 - d6;
        if (d1 <= 0 && d2 <= 0) begin
            r.rgn = cpt_pkg::RGN_A;
        end else if (d3 >= 0 && d4 <= d3) begin
            r.rgn = cpt_pkg::RGN_B; wt[0] = 0; wt[1] = 17'(ONE);
        end else if (vc <= 0 && d1 >= 0 && d3 <= 0) begin
            r.rgn = cpt_pkg::RGN_AB; t = weight_of(d1, d1 - d3);
            wt[0] = 17'(ONE) - t; wt[1] = t;
        end else if (d6 >= 0 && d5 <= d6) begin
            r.rgn = cpt_pkg::RGN_C; wt[0] = 0; wt[2] = 17'(ONE);
        end else if (vb <= 0 && d2 >= 0 && d6 <= 0) begin
            r.rgn = cpt_pkg::RGN_AC; t = weight_of(d2, d2 - d6);
            wt[0] = 17'(ONE) - t; wt[2] = t;
        end else if (va <= 0 && e1 >= 0 && e2 >= 0) begin
            r.rgn = cpt_pkg::RGN_BC; t = weight_of(e1, e1 + e2);
            wt[0] = 0; wt[1] = 17'(ONE) - t; wt[2] = t;
        end else begin
            den = va + vb + vc;
            if (den <= 0) begin
                r.rgn = cpt_pkg::RGN_A; r.degen = 1;
            end else begin
                r.rgn = cpt_pkg::RGN_IN;
                v = weight_of(vb, den); w = weight_of(vc, den);
                if (18'(v) + 18'(w) > ONE) w = 17'(ONE) - v;
                wt[0] = 17'(ONE) - v - w; wt[1] = v; wt[2] = w;
            end
        end
        dist_sq = 0;
        for (int k = 0; k < 3; k++) begin
            s = wide_t'(wt[0]) * a[k] + wide_t'(wt[1]) * b[k] + wide_t'(wt[2]) * cc[k]
                + (ONE / 2);
            s = s >>> 16;
            nr[k] = s[31:0];
            dd = p[k] - s;
            dist_sq = dist_sq + dd * dd;
        end
        r.nx = nr[0]; r.ny = nr[1]; r.nz = nr[2];
        r.wa = wt[0]; r.wb = wt[1]; r.wc = wt[2];
        r.dsq = (dist_sq >= (wide_t'(1) <<< 63)) ? {63{1'b1}} : dist_sq[62:0];
        return r;
    endfunction

    function automatic query_t row(int qx, int qy, int qz, int ax, int ay, int az,
                                   int bx, int by, int bz, int cx, int cy, int cz);
        query_t r;
        r.c = '{qx, qy, qz, ax, ay, az, bx, by, bz, cx, cy, cz};
        r.typed = 0;
        r.want = closest_point(r.c);
        return r;
    endfunction

    function automatic query_t typed_row(query_t r, cpt_pkg::region_t rgn, logic degen,
                                         int wa, int wb, int wc, int nx, int ny, int nz);
        r.typed = 1;
        r.want = '{nx, ny, nz, 17'(wa), 17'(wb), 17'(wc), 63'd0, rgn, degen};
        return r;
    endfunction

    function automatic void add_row(query_t r);
        table_rows = {table_rows, r};
    endfunction

    function automatic coord_t rnd_coord(int shift_lo);
        return coord_t'($urandom) >>> $urandom_range(shift_lo, 31);
    endfunction

    function automatic query_t rnd_query();
        query_t r;
        int mode = $urandom_range(0, 99);
        coord_t base, k;
        if (mode < 20) begin
            for (int i = 0; i < 12; i++) r.c[i] = coord_t'($urandom);
        end else begin
            for (int i = 0; i < 3; i++) begin
                base = rnd_coord(8);
                for (int j = 0; j < 4; j++) r.c[3 * j + i] = base + rnd_coord(10);
            end
            if (mode < 30) begin
                // collinear corners
                k = $urandom_range(0, 4) - 2;
                for (int i = 0; i < 3; i++)
                    r.c[9 + i] = r.c[3 + i] + k * (r.c[6 + i] - r.c[3 + i]);
            end else if (mode < 34) begin
                for (int i = 0; i < 3; i++) r.c[6 + i] = r.c[3 + i];
            end
        end
        r.typed = 0;
        r.want = closest_point(r.c);
        return r;
    endfunction

    task automatic send(query_t q);
        while ($urandom_range(0, 99) < idle_pct) begin
            s_tvalid <= 0;
            @(negedge aclk);
        end
        cur = q;
        s_tvalid <= 1;
        for (int i = 0; i < 12; i++) s_tdata[32 * i +: 32] <= q.c[i];
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    // receiver side: random stalls plus a long hold-off on request
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_tready <= 0;
        end else begin
            m_tready <= aresetn && ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin
        nearest_t e, got;
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
        if (aresetn && s_tvalid && s_tready)
            nearest_q = {nearest_q, (cur.typed ? cur.want : closest_point(cur.c))};
        if (aresetn && m_tvalid && m_tready) begin
            got.nx = m_tdata[0 +: 32];
            got.ny = m_tdata[32 +: 32];
            got.nz = m_tdata[64 +: 32];
            got.wa = m_tdata[cpt_pkg::M_WA_LO +: 17];
            got.wb = m_tdata[cpt_pkg::M_WB_LO +: 17];
            got.wc = m_tdata[cpt_pkg::M_WC_LO +: 17];
            got.dsq = m_tdata[cpt_pkg::M_DST_LO +: 63];
            got.rgn = cpt_pkg::region_t'(m_tuser[2:0]);
            got.degen = m_tuser[3];
            if (nearest_q.size() == 0) begin
                $display("%0t: unexpected beat, actual %p", $time, got);
                failed = 1;
            end else begin
                e = nearest_q.pop_front();
                if (got.nx !== e.nx || got.ny !== e.ny || got.nz !== e.nz
                    || got.wa !== e.wa || got.wb !== e.wb || got.wc !== e.wc
                    || got.dsq !== e.dsq || got.rgn !== e.rgn || got.degen !== e.degen) begin
                    $display("%0t: mismatch expected %p actual %p", $time, e, got);
                    failed = 1;
                end
            end
        end
    end

    initial begin
        coord_t mx, mn;
        mx = 32'sh7fffffff; mn = 32'sh80000000;
        add_row(typed_row(row(0,0,0, 0,0,0, 0,0,0, 0,0,0),
                cpt_pkg::RGN_A, 0, ONE, 0, 0, 0, 0, 0));
        add_row(typed_row(row(0,0,0, 0,0,0, 4*ONE,0,0, 0,4*ONE,0),
                cpt_pkg::RGN_A, 0, ONE, 0, 0, 0, 0, 0));
        add_row(typed_row(row(4*ONE,0,0, 0,0,0, 4*ONE,0,0, 0,4*ONE,0),
                cpt_pkg::RGN_B, 0, 0, ONE, 0, 4*ONE, 0, 0));
        add_row(typed_row(row(0,4*ONE,0, 0,0,0, 4*ONE,0,0, 0,4*ONE,0),
                cpt_pkg::RGN_C, 0, 0, 0, ONE, 0, 4*ONE, 0));
        add_row(typed_row(row(mx,mx,mx, mx,mx,mx, mx,mx,mx, mx,mx,mx),
                cpt_pkg::RGN_A, 0, ONE, 0, 0, mx, mx, mx));
        add_row(typed_row(row(mn,mn,mn, mn,mn,mn, mn,mn,mn, mn,mn,mn),
                cpt_pkg::RGN_A, 0, ONE, 0, 0, mn, mn, mn));
        add_row(row(2*ONE,-ONE,0, 0,0,0, 4*ONE,0,0, 0,4*ONE,0));
        add_row(row(-ONE,2*ONE,ONE, 0,0,0, 4*ONE,0,0, 0,4*ONE,0));
        add_row(row(3*ONE,3*ONE,-ONE, 0,0,0, 4*ONE,0,0, 0,4*ONE,0));
        add_row(row(ONE,ONE,5*ONE, 0,0,0, 4*ONE,0,0, 0,4*ONE,0));
        add_row(row(-ONE,-ONE,0, 0,0,0, 4*ONE,0,0, 0,4*ONE,0));
        add_row(row(5*ONE,-ONE,0, 0,0,0, 4*ONE,0,0, 0,4*ONE,0));
        add_row(row(-ONE,5*ONE,0, 0,0,0, 4*ONE,0,0, 0,4*ONE,0));
        add_row(row(ONE,ONE,0, 0,0,0, 0,0,0, 0,4*ONE,0));
        add_row(row(3*ONE,ONE,0, ONE,0,0, 2*ONE,0,0, 3*ONE,0,0));
        add_row(row(mx,mx,mx, mn,mn,mn, mn,mx,mn, mx,mn,mn));
        add_row(row(mn,mn,mn, mx,mx,mx, mx,mn,mx, mn,mx,mx));
        add_row(row(mx,mn,mx, mn,mx,mn, mx,mx,mn, mn,mn,mx));
        add_row(row(0,0,mx, mn,mn,0, mx,mn,0, 0,mx,0));
        add_row(row(1,1,1, 0,0,0, 3,0,0, 0,3,0));
        add_row(row(-1,-1,-1, -1,0,0, 0,-1,0, 0,0,-1));

        repeat (7) @(posedge aclk);
        aresetn <= 1;
        @(negedge aclk);

        foreach (table_rows[i]) send(table_rows[i]);
        for (int ph = 0; ph < 4; ph++) begin
            idle_pct  = (ph == 1 || ph == 3) ? (ph == 1 ? 86 : 21) : 0;
            stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 86 : 21) : 0;
            if (ph == 0) hold_left = 300;
            for (int n = 0; n < N_RND / 4; n++) send(rnd_query());
        end
        s_tvalid <= 0;
        idle_pct = 0;
        stall_pct = 0;

        wait (nearest_q.size() == 0);
        repeat (40) @(posedge aclk);
        if (!failed && nearest_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
